[rtl/core/rtfue_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfue_pkg
// shared types, character codes and the fixed escape table of the encoder
// ----------------------------------------------------------------------------
package rtfue_pkg;

   localparam int MAX_BYTES = 11;
   localparam int IDX_W     = $clog2(MAX_BYTES);
   localparam int CU_W      = 16;
   localparam int CH_W      = 7;

   localparam logic [CH_W-1:0] CH_BSLASH = 7'h5C;
   localparam logic [CH_W-1:0] CH_U      = 7'h75;
   localparam logic [CH_W-1:0] CH_MINUS  = 7'h2D;
   localparam logic [CH_W-1:0] CH_QUEST  = 7'h3F;
   localparam logic [CH_W-1:0] CH_ZERO   = 7'h30;

   // x * 0xcccd >> 19 is x / 10 for every 16 bit x
   localparam logic [CU_W-1:0] DIV10_RECIP = 16'hCCCD;
   localparam int              DIV10_SHIFT = 19;

   typedef struct packed {
      logic [CU_W-1:0] quot;
      logic [3:0]      rem;
   } div10_type;

   typedef struct packed {
      logic                     hit;
      logic [IDX_W-1:0]         len;
      logic [8*MAX_BYTES-1:0]   text;   // first byte in the top bits
   } esc_type;

   function automatic esc_type escape_lookup(input logic [CU_W-1:0] code);
      esc_type                r;
      logic [8*MAX_BYTES-1:0] lit;
      logic [IDX_W-1:0]       n;
      int                     sh;
      lit = '0;
      n   = '0;
      r.hit = 1'b1;
      case (code)
         16'h0009: begin lit = "\\tab ";        n = 4'd5;  end
         16'h005C: begin lit = "\\'5c";         n = 4'd4;  end
         16'h007B: begin lit = "\\'7b";         n = 4'd4;  end
         16'h007D: begin lit = "\\'7d";         n = 4'd4;  end
         16'h00A0: begin lit = "\\~";           n = 4'd2;  end
         16'h00AD: begin lit = "\\-";           n = 4'd2;  end
         16'h00B7: begin lit = "\\|";           n = 4'd2;  end
         16'h2002: begin lit = "\\enspace ";    n = 4'd9;  end
         16'h2003: begin lit = "\\emspace ";    n = 4'd9;  end
         16'h2004: begin lit = "\\qmspace ";    n = 4'd9;  end
         16'h200C: begin lit = "\\zwnj ";       n = 4'd6;  end
         16'h200D: begin lit = "\\zwj ";        n = 4'd5;  end
         16'h200E: begin lit = "\\ltrmark ";    n = 4'd9;  end
         16'h200F: begin lit = "\\rtlmark ";    n = 4'd9;  end
         16'h2011: begin lit = "\\_";           n = 4'd2;  end
         16'h2013: begin lit = "\\endash ";     n = 4'd8;  end
         16'h2014: begin lit = "\\emdash ";     n = 4'd8;  end
         16'h2018: begin lit = "\\lquote ";     n = 4'd8;  end
         16'h2019: begin lit = "\\rquote ";     n = 4'd8;  end
         16'h201C: begin lit = "\\ldblquote ";  n = 4'd11; end
         16'h201D: begin lit = "\\rdblquote ";  n = 4'd11; end
         16'h2022: begin lit = "\\bullet ";     n = 4'd8;  end
         16'h2028: begin lit = "\\line ";       n = 4'd6;  end
         default:  begin r.hit = 1'b0;                     end
      endcase
      sh     = 8 * (MAX_BYTES - int'(n));
      r.len  = n;
      r.text = lit << sh;
      return r;
   endfunction

endpackage

[rtl/core/rtfue_div10.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfue_div10
// shared divide-by-ten unit: quotient and decimal digit of a 16 bit value
// ----------------------------------------------------------------------------
module rtfue_div10 (
   input  logic [rtfue_pkg::CU_W-1:0] value,
   output rtfue_pkg::div10_type       res
);

   logic [2*rtfue_pkg::CU_W-1:0] prod;
   logic [rtfue_pkg::CU_W-1:0]   quot;
   logic [rtfue_pkg::CU_W-1:0]   back;
   logic [rtfue_pkg::CU_W-1:0]   diff;

   // reciprocal multiply
   assign prod = (2*rtfue_pkg::CU_W)'(value) * (2*rtfue_pkg::CU_W)'(rtfue_pkg::DIV10_RECIP);
   assign quot = rtfue_pkg::CU_W'(prod >> rtfue_pkg::DIV10_SHIFT);
   // quot * 10 as two shifts
   assign back = rtfue_pkg::CU_W'({quot, 3'b000}) + rtfue_pkg::CU_W'({quot, 1'b0});
   assign diff = value - back;

   assign res.quot = quot;
   assign res.rem  = diff[3:0];

endmodule

[rtl/core/rtf_unicode_escape_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_unicode_escape_encoder
// turns one utf-16 code unit into its rtf escape, one ascii byte per word
// ----------------------------------------------------------------------------
// latency: first byte is valid in the cycle after the code unit is accepted for
//   fixed escapes and plain ascii; the \u form first writes its digits in conv
// throughput: a run is the n bytes of a fixed escape (2 to 11) or d + 3 or 4
//   bytes for \u with d decimal digits; a new code unit is taken only in idle,
//   after the last byte has left; the shared divide-by-ten unit makes one digit a
//   cycle and one byte a cycle goes out while rsp_tready is high
// reset: synchronous, returns the sequencer to idle; nothing is kept per word
// ----------------------------------------------------------------------------
module rtf_unicode_escape_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] code_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [6:0] out_byte, [7] zero
   output logic        rsp_tlast     // last_of_run
);

   localparam int NB = rtfue_pkg::MAX_BYTES;
   localparam int IW = rtfue_pkg::IDX_W;
   localparam int CW = rtfue_pkg::CH_W;
   localparam int UW = rtfue_pkg::CU_W;

   // idle waits for a code unit, conv makes one digit a cycle, emit drains
   typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_type;

   state_type        state_ff, state_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    len_ff, len_in;
   logic [UW-1:0]    mag_ff, mag_in;

   // byte buffer, payload only
   logic [CW-1:0]    buf_ff   [0:NB-1];
   logic [CW-1:0]    load_buf [0:NB-1];

   logic             accept;
   logic             out_fire;
   logic             last_byte;
   rtfue_pkg::esc_type   esc;
   rtfue_pkg::div10_type dv;

   logic             printable;
   logic             neg;
   logic [UW-1:0]    mag_new;
   logic [2:0]       ndig;
   logic [IW-1:0]    pre_len;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign out_fire   = rsp_tvalid && rsp_tready;
   assign last_byte  = (rd_ptr_ff == len_ff - IW'(1));
   assign rsp_tdata  = {1'b0, buf_ff[rd_ptr_ff]};
   assign rsp_tlast  = last_byte;

   // ---------------------------------------------------------------------
   // classify the incoming code unit
   // ---------------------------------------------------------------------
   assign esc       = rtfue_pkg::escape_lookup(req_tdata);
   assign printable = (req_tdata >= 16'h0020) && (req_tdata < 16'h0080);
   // 0x8000 and up is shown as cu - 0x10000, magnitude is the two's negate
   assign neg       = req_tdata[UW-1];
   assign mag_new   = neg ? (~req_tdata + UW'(1)) : req_tdata;
   assign pre_len   = neg ? IW'(3) : IW'(2);

   // decimal digit count from four parallel compares
   always_comb begin
      ndig = 3'd1 + 3'(mag_new >= UW'(10)) + 3'(mag_new >= UW'(100))
           + 3'(mag_new >= UW'(1000)) + 3'(mag_new >= UW'(10000));
   end

   // initial buffer image: table text, the byte itself, or "\u[-]" and '?'
   // filler where digits get overwritten and the trailing '?' stays
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         if (esc.hit) begin
            load_buf[i] = esc.text[8*(NB-1-i) +: CW];
         end else if (printable) begin
            load_buf[i] = req_tdata[CW-1:0];
         end else if (i == 0) begin
            load_buf[i] = rtfue_pkg::CH_BSLASH;
         end else if (i == 1) begin
            load_buf[i] = rtfue_pkg::CH_U;
         end else if (i == 2 && neg) begin
            load_buf[i] = rtfue_pkg::CH_MINUS;
         end else begin
            load_buf[i] = rtfue_pkg::CH_QUEST;
         end
      end
   end

   // ---------------------------------------------------------------------
   // shared divider, one digit per conv cycle, least significant first
   // ---------------------------------------------------------------------
   rtfue_div10 u_div10 (
      .value (mag_ff),
      .res   (dv)
   );

   // ---------------------------------------------------------------------
   // sequencer next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      len_in    = len_ff;
      mag_in    = mag_ff;
      case (state_ff)
         S_IDLE: begin
            rd_ptr_in = '0;
            if (accept) begin
               if (esc.hit) begin
                  len_in   = esc.len;
                  state_in = S_EMIT;
               end else if (printable) begin
                  len_in   = IW'(1);
                  state_in = S_EMIT;
               end else begin
                  // prefix, digits, then '?'
                  len_in    = pre_len + IW'(ndig) + IW'(1);
                  wr_ptr_in = pre_len + IW'(ndig) - IW'(1);
                  mag_in    = mag_new;
                  state_in  = S_CONV;
               end
            end
         end
         S_CONV: begin
            mag_in    = dv.quot;
            wr_ptr_in = wr_ptr_ff - IW'(1);
            // quotient zero means the most significant digit was just written
            if (dv.quot == '0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_fire) begin
               if (last_byte) begin
                  state_in = S_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         len_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         len_ff    <= len_in;
      end
   end

   // magnitude and buffer are payload
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      if (accept) begin
         for (int i = 0; i < NB; i++) begin
            buf_ff[i] <= load_buf[i];
         end
      end else if (state_ff == S_CONV) begin
         buf_ff[wr_ptr_ff] <= rtfue_pkg::CH_ZERO + CW'(dv.rem);
      end
   end

endmodule

[verif/rtfue_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfue_checker
// watches both streams of the escape encoder, predicts every byte and compares
// ----------------------------------------------------------------------------
module rtfue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          bytes_outstanding
);

   typedef struct packed {
      logic [15:0] code_unit;
      logic [6:0]  ch;
      logic        last;
   } escape_byte_type;

   escape_byte_type escape_bytes_due[$];

   initial begin
      mismatch_count    = 0;
      bytes_outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count = mismatch_count + 1;
   endtask

   // fixed control words; empty string when the code unit has none
   function automatic string control_word(input logic [15:0] cu);
      case (cu)
         16'h0009: return "\\tab ";
         16'h005C: return "\\'5c";
         16'h007B: return "\\'7b";
         16'h007D: return "\\'7d";
         16'h00A0: return "\\~";
         16'h00AD: return "\\-";
         16'h00B7: return "\\|";
         16'h2002: return "\\enspace ";
         16'h2003: return "\\emspace ";
         16'h2004: return "\\qmspace ";
         16'h200C: return "\\zwnj ";
         16'h200D: return "\\zwj ";
         16'h200E: return "\\ltrmark ";
         16'h200F: return "\\rtlmark ";
         16'h2011: return "\\_";
         16'h2013: return "\\endash ";
         16'h2014: return "\\emdash ";
         16'h2018: return "\\lquote ";
         16'h2019: return "\\rquote ";
         16'h201C: return "\\ldblquote ";
         16'h201D: return "\\rdblquote ";
         16'h2022: return "\\bullet ";
         16'h2028: return "\\line ";
         default:  return "";
      endcase
   endfunction

   function automatic void predict_escape(input logic [15:0] cu);
      string      txt;
      int         mag;
      logic [7:0] c;
      txt = control_word(cu);
      if (txt == "") begin
         if (cu >= 16'h0020 && cu < 16'h0080) begin
            txt = $sformatf("%c", cu[7:0]);
         end else if (cu >= 16'h8000) begin
            mag = 32'h10000 - int'(cu);
            txt = $sformatf("\\u-%0d?", mag);
         end else begin
            mag = int'(cu);
            txt = $sformatf("\\u%0d?", mag);
         end
      end
      for (int i = 0; i < txt.len(); i++) begin
         c = txt[i];
         escape_bytes_due.push_back('{cu, c[6:0], i == txt.len() - 1});
      end
   endfunction

   always @(posedge clock) begin
      escape_byte_type due;
      if (reset) begin
         escape_bytes_due.delete();
      end else begin
         // results first: a word leaving now never belongs to a code unit entering now
         if (rsp_tvalid && rsp_tready) begin
            if (escape_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word %02h last %0b", rsp_tdata, rsp_tlast));
            end else begin
               due = escape_bytes_due.pop_front();
               if (rsp_tdata !== {1'b0, due.ch})
                  report_mismatch($sformatf("code unit %04h: byte %02h, want %02h",
                                            due.code_unit, rsp_tdata, {1'b0, due.ch}));
               if (rsp_tlast !== due.last)
                  report_mismatch($sformatf("code unit %04h byte %02h: last %0b, want %0b",
                                            due.code_unit, rsp_tdata, rsp_tlast, due.last));
            end
         end
         if (req_tvalid && req_tready)
            predict_escape(req_tdata);
      end
      bytes_outstanding = escape_bytes_due.size();
   end

endmodule

[verif/tb_rtf_unicode_escape_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtf_unicode_escape_encoder
// drives code units into the rtf escape encoder with random stalls on both
// streams; a checker beside the block predicts and compares every word
// ----------------------------------------------------------------------------
module tb_rtf_unicode_escape_encoder;

   localparam int RANDOM_UNITS   = 445;
   localparam int CALM_TAIL      = 80;    // last code units sent with no idling
   localparam int DRAIN_CYCLES   = 20;    // longest \u escape plus margin
   localparam int WATCHDOG_LIMIT = 1000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;      // [15:0] code_unit
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [6:0] out_byte, [7] zero
   logic        rsp_tlast;            // last_of_run

   int          mismatch_count;
   int          bytes_outstanding;
   bit          idle_on = 1'b1;
   int          stall_left = 0;
   int          stuck_cycles = 0;

   // code units with a fixed control word
   logic [15:0] control_codes [23] = '{
      16'h0009, 16'h005C, 16'h007B, 16'h007D, 16'h00A0, 16'h00AD, 16'h00B7,
      16'h2002, 16'h2003, 16'h2004, 16'h200C, 16'h200D, 16'h200E, 16'h200F,
      16'h2011, 16'h2013, 16'h2014, 16'h2018, 16'h2019, 16'h201C, 16'h201D,
      16'h2022, 16'h2028
   };

   // extremes, ascii edges, decimal width edges and surrogates
   logic [15:0] directed_units [25] = '{
      16'h0000, 16'h0001, 16'h0009, 16'h000A, 16'h001F, 16'h0020, 16'h0041,
      16'h005C, 16'h007B, 16'h007D, 16'h007E, 16'h007F, 16'h0080, 16'h00A0,
      16'h201C, 16'h201D, 16'h2027, 16'h270F, 16'h2710, 16'h7FFF, 16'h8000,
      16'h8001, 16'hD800, 16'hDFFF, 16'hFFFF
   };

   rtf_unicode_escape_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   rtfue_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver side: random stall bursts while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ends the run if neither stream moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // mostly control words, ascii and their neighbors; the rest spans all 16 bits
   function automatic logic [15:0] pick_code_unit();
      int          sel;
      logic [15:0] cu;
      sel = $urandom_range(0, 99);
      if (sel < 35)
         cu = control_codes[$urandom_range(0, 22)];
      else if (sel < 45)
         cu = control_codes[$urandom_range(0, 22)] + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
      else if (sel < 65)
         cu = 16'($urandom_range(32, 127));
      else if (sel < 75)
         cu = 16'($urandom_range(0, 31));
      else
         cu = 16'($urandom());
      return cu;
   endfunction

   // one word on the request stream; valid stays high between back-to-back words
   task automatic send_code_unit(input logic [15:0] cu);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cu;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_units[i])
         send_code_unit(directed_units[i]);

      for (int n = 0; n < RANDOM_UNITS; n++) begin
         // a quiet stretch in the middle, and none at all near the end
         idle_on = !((n >= 150 && n < 200) || n >= RANDOM_UNITS - CALM_TAIL);
         send_code_unit(pick_code_unit());
      end
      req_tvalid <= 1'b0;

      // wait on the clock so the checker has booked the last code unit's bytes
      @(posedge clock);
      wait (bytes_outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rtfue_pkg.sv
rtl/core/rtfue_div10.sv
rtl/core/rtf_unicode_escape_encoder.sv
verif/rtfue_checker.sv
verif/tb_rtf_unicode_escape_encoder.sv
